// File: rtl/tscd_pkg.sv
// Shared types and constants for the thumb-shift chord detector.
// No dependencies; every other file in rtl/ refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package tscd_pkg;

  // Key event codes carried in the func field.
  typedef enum logic [2:0] {
    EV_INIT     = 3'd0,
    EV_ALL_OFF  = 3'd1,
    EV_CHAR     = 3'd2,
    EV_THUMB    = 3'd3,
    EV_RELEASE  = 3'd4,
    EV_TICK     = 3'd5
  } ev_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_THUMB = 2'd1,
    KIND_LONG  = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CHAR_TIMEOUT  = 3'd0,
    CFG_THUMB_TIMEOUT = 3'd1,
    CFG_OVERLAP       = 3'd2,
    CFG_DEDICATED     = 3'd3
  } cfg_idx_t;

  localparam int unsigned CODE_W   = 16;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NOW_W    = 32;

  localparam logic [CFG_W-1:0] CHAR_TIMEOUT_RST  = 10'd100;
  localparam logic [CFG_W-1:0] THUMB_TIMEOUT_RST = 10'd100;
  localparam logic [CFG_W-1:0] OVERLAP_RST       = 10'd50;

  typedef struct packed {
    logic [CFG_W-1:0] char_timeout;
    logic [CFG_W-1:0] thumb_timeout;
    logic [CFG_W-1:0] overlap_window;
    logic             dedicated_thumb_keys;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [CODE_W-1:0] char_code;
    logic [CODE_W-1:0] thumb_code;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/tscd_in_if.sv
// Input channel of the chord detector: one key event per transfer.
// Field widths come from tscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tscd_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    func;
  logic [tscd_pkg::CODE_W-1:0]   key_code;
  logic [tscd_pkg::NOW_W-1:0]    now_ms;
  logic                          shift_held;

  modport source (output valid, func, key_code, now_ms, shift_held, input ready);
  modport sink   (input valid, func, key_code, now_ms, shift_held, output ready);
endinterface

`default_nettype wire

// File: rtl/tscd_out_if.sv
// Result channel of the chord detector: one detected stroke per transfer.
// Field widths come from tscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tscd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [tscd_pkg::CODE_W-1:0] char_code;
  logic [tscd_pkg::CODE_W-1:0] thumb_code;

  modport source (output valid, kind, char_code, thumb_code, input ready);
  modport sink   (input valid, kind, char_code, thumb_code, output ready);
endinterface

`default_nettype wire

// File: rtl/tscd_cfg_if.sv
// Configuration write channel: register index and write data per transfer.
// Register indexes are listed in tscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tscd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tscd_pkg::CFG_IDX_W-1:0] index;
  logic [tscd_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/tscd_fsm.sv
// Chord state machine: pending keys, press times, deadline and the
// per-event decision logic. Uses types from tscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tscd_fsm #(
  parameter int unsigned SHIFT_THUMB_CODE = 255,
  parameter int unsigned TIME_BITS        = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [2:0]           func,
  input  wire logic [15:0]          key_code,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic                 shift_held,
  input  wire tscd_pkg::cfg_t       cfg,
  output tscd_pkg::res_t            res
);
  import tscd_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT       = 3'd0,
    ST_CHAR       = 3'd1,
    ST_THUMB      = 3'd2,
    ST_CHAR_THUMB = 3'd3,
    ST_THUMB_CHAR = 3'd4
  } state_t;

  localparam logic [CODE_W-1:0] SHIFT_CODE = CODE_W'(SHIFT_THUMB_CODE);

  state_t                st_r, st_nxt;
  logic [CODE_W-1:0]     pc_r, pc_nxt;
  logic [CODE_W-1:0]     pt_r, pt_nxt;
  logic [TIME_BITS-1:0]  ct_r, ct_nxt;
  logic [TIME_BITS-1:0]  tt_r, tt_nxt;
  logic [TIME_BITS-1:0]  dl_r, dl_nxt;

  logic [TIME_BITS-1:0]  d_thumb_char, d_char_thumb, d_now_thumb, d_now_char;
  logic [TIME_BITS-1:0]  char_dl, thumb_dl, overlap;
  logic                  go;
  ev_t                   ev;

  function automatic res_t emit_f(input logic [CODE_W-1:0] ch,
                                  input logic [CODE_W-1:0] th,
                                  input logic              sh);
    res_t r;
    r = '0;
    if (ch == '0) begin
      if (th != '0) begin
        r.valid      = 1'b1;
        r.kind       = KIND_THUMB;
        r.thumb_code = th;
      end
    end else begin
      r.valid      = 1'b1;
      r.kind       = KIND_CHAR;
      r.char_code  = ch;
      r.thumb_code = (sh && th == '0) ? SHIFT_CODE : th;
    end
    return r;
  endfunction

  assign ev           = ev_t'(func);
  assign d_thumb_char = tt_r - ct_r;
  assign d_char_thumb = ct_r - tt_r;
  assign d_now_thumb  = now - tt_r;
  assign d_now_char   = now - ct_r;
  assign char_dl      = now + TIME_BITS'(cfg.char_timeout);
  assign thumb_dl     = now + TIME_BITS'(cfg.thumb_timeout);
  assign overlap      = TIME_BITS'(cfg.overlap_window);

  // A tick only reaches the machine once its deadline has passed.
  always_comb begin
    if (func > EV_TICK) begin
      go = 1'b0;
    end else if (ev == EV_TICK) begin
      go = (dl_r != '0) && (now > dl_r);
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    pc_nxt = pc_r;
    pt_nxt = pt_r;
    ct_nxt = ct_r;
    tt_nxt = tt_r;
    dl_nxt = dl_r;
    res    = '0;
    if (step && go) begin
      if (ev == EV_TICK) begin
        dl_nxt = '0;
      end
      unique case (st_r)
        ST_INIT: begin
          pc_nxt = '0;
          pt_nxt = '0;
          ct_nxt = '0;
          tt_nxt = '0;
          dl_nxt = '0;
          if (ev == EV_CHAR) begin
            pc_nxt = key_code;
            ct_nxt = now;
            dl_nxt = char_dl;
            st_nxt = ST_CHAR;
          end else if (ev == EV_THUMB) begin
            pt_nxt = key_code;
            tt_nxt = now;
            dl_nxt = thumb_dl;
            st_nxt = ST_THUMB;
          end
        end
        ST_CHAR: begin
          case (ev)
            EV_INIT: st_nxt = ST_INIT;
            EV_ALL_OFF, EV_TICK: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pc_nxt = '0;
              pt_nxt = '0;
              st_nxt = ST_INIT;
            end
            EV_CHAR: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pt_nxt = '0;
              pc_nxt = key_code;
              ct_nxt = now;
              dl_nxt = char_dl;
            end
            EV_THUMB: begin
              pt_nxt = key_code;
              tt_nxt = now;
              dl_nxt = thumb_dl;
              st_nxt = ST_CHAR_THUMB;
            end
            EV_RELEASE: begin
              if (key_code == pc_r) begin
                res    = emit_f(pc_r, pt_r, shift_held);
                pc_nxt = '0;
                pt_nxt = '0;
                st_nxt = ST_INIT;
              end
            end
            default: ;
          endcase
        end
        ST_THUMB: begin
          case (ev)
            EV_INIT: st_nxt = ST_INIT;
            EV_ALL_OFF: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pc_nxt = '0;
              pt_nxt = '0;
              st_nxt = ST_INIT;
            end
            EV_CHAR: begin
              pc_nxt = key_code;
              ct_nxt = now;
              dl_nxt = char_dl;
              st_nxt = ST_THUMB_CHAR;
            end
            EV_THUMB: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pc_nxt = '0;
              pt_nxt = key_code;
              tt_nxt = now;
              dl_nxt = thumb_dl;
            end
            EV_RELEASE: begin
              if (key_code == pt_r) begin
                res    = emit_f(pc_r, pt_r, shift_held);
                pc_nxt = '0;
                pt_nxt = '0;
                st_nxt = ST_INIT;
              end
            end
            EV_TICK: begin
              // With dedicated thumb keys the time-out only drops the deadline.
              if (!cfg.dedicated_thumb_keys) begin
                if (pt_r != '0) begin
                  res.valid      = 1'b1;
                  res.kind       = KIND_LONG;
                  res.thumb_code = pt_r;
                end
                pc_nxt = '0;
                pt_nxt = '0;
                st_nxt = ST_INIT;
              end
            end
            default: ;
          endcase
        end
        ST_CHAR_THUMB: begin
          case (ev)
            EV_INIT: st_nxt = ST_INIT;
            EV_ALL_OFF, EV_TICK: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pc_nxt = '0;
              pt_nxt = '0;
              st_nxt = ST_INIT;
            end
            EV_THUMB: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pc_nxt = '0;
              pt_nxt = key_code;
              tt_nxt = now;
              dl_nxt = thumb_dl;
              st_nxt = ST_THUMB;
            end
            EV_CHAR: begin
              // The thumb joins whichever character was pressed nearer to it.
              if (d_thumb_char < d_now_thumb) begin
                res    = emit_f(pc_r, pt_r, shift_held);
                pt_nxt = '0;
                st_nxt = ST_CHAR;
              end else begin
                res    = emit_f(pc_r, '0, shift_held);
                st_nxt = ST_THUMB_CHAR;
              end
              pc_nxt = key_code;
              ct_nxt = now;
              dl_nxt = char_dl;
            end
            EV_RELEASE: begin
              if (pc_r == key_code && d_now_thumb < overlap &&
                  d_thumb_char >= d_now_thumb) begin
                res    = emit_f(pc_r, '0, shift_held);
                pc_nxt = '0;
                st_nxt = ST_THUMB;
              end else begin
                res    = emit_f(pc_r, pt_r, shift_held);
                pc_nxt = '0;
                pt_nxt = '0;
                st_nxt = ST_INIT;
              end
            end
            default: ;
          endcase
        end
        ST_THUMB_CHAR: begin
          case (ev)
            EV_INIT: st_nxt = ST_INIT;
            EV_ALL_OFF, EV_TICK: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pc_nxt = '0;
              pt_nxt = '0;
              st_nxt = ST_INIT;
            end
            EV_CHAR: begin
              res    = emit_f(pc_r, pt_r, shift_held);
              pt_nxt = '0;
              pc_nxt = key_code;
              ct_nxt = now;
              dl_nxt = char_dl;
              st_nxt = ST_CHAR;
            end
            EV_THUMB: begin
              if (d_char_thumb < d_now_char) begin
                res    = emit_f(pc_r, pt_r, shift_held);
                pc_nxt = '0;
                st_nxt = ST_THUMB;
              end else begin
                res    = emit_f('0, pt_r, shift_held);
                st_nxt = ST_CHAR_THUMB;
              end
              pt_nxt = key_code;
              tt_nxt = now;
              dl_nxt = thumb_dl;
            end
            EV_RELEASE: begin
              if (pt_r == key_code && d_now_char < overlap &&
                  d_char_thumb >= d_now_char) begin
                res    = emit_f('0, pt_r, shift_held);
                pt_nxt = '0;
                st_nxt = ST_CHAR;
              end else begin
                res    = emit_f(pc_r, pt_r, shift_held);
                pc_nxt = '0;
                pt_nxt = '0;
                st_nxt = ST_INIT;
              end
            end
            default: ;
          endcase
        end
        default: st_nxt = ST_INIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_INIT;
      pc_r <= '0;
      pt_r <= '0;
      ct_r <= '0;
      tt_r <= '0;
      dl_r <= '0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      pt_r <= pt_nxt;
      ct_r <= ct_nxt;
      tt_r <= tt_nxt;
      dl_r <= dl_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/thumb_shift_chord_detector_core.sv
// Top level of the thumb-shift chord detector: event input register,
// configuration registers, result register. Uses tscd_pkg, the channel
// interfaces and tscd_fsm.
//
//   channel   direction  transfer moves
//   in_ch     sink       func, key_code, now_ms, shift_held
//   out_ch    source     kind, char_code, thumb_code
//   cfg_ch    sink       index, data (always ready)
//
// One event per cycle sustained while out_ch takes each result. An event is
// held in the input register, then passes the decision logic into the result
// register. A full result register stalls the event stage when out_ch is not
// ready, and in_ch stays ready while the input register can move on. Reset
// (rst_n low at a clock edge) empties both stages, clears the state machine
// and restores the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module thumb_shift_chord_detector_core #(
  parameter int unsigned SHIFT_THUMB_CODE = 255,
  parameter int unsigned TIME_BITS        = 32
) (
  input wire logic    clk,
  input wire logic    rst_n,
  tscd_in_if.sink     in_ch,
  tscd_out_if.source  out_ch,
  tscd_cfg_if.sink    cfg_ch
);
  import tscd_pkg::*;

  logic                 in_v_r;
  logic [2:0]           func_r;
  logic [CODE_W-1:0]    key_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 shift_r;

  logic                 out_v_r;
  kind_t                kind_r;
  logic [CODE_W-1:0]    char_r;
  logic [CODE_W-1:0]    thumb_r;

  cfg_t                 cfg_r;
  res_t                 res;
  logic                 advance;

  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_v_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.char_code  = char_r;
  assign out_ch.thumb_code = thumb_r;

  tscd_fsm #(
    .SHIFT_THUMB_CODE (SHIFT_THUMB_CODE),
    .TIME_BITS        (TIME_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .func       (func_r),
    .key_code   (key_r),
    .now        (now_r),
    .shift_held (shift_r),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Event input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      func_r  <= in_ch.func;
      key_r   <= in_ch.key_code;
      now_r   <= TIME_BITS'(in_ch.now_ms);
      shift_r <= in_ch.shift_held;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res.valid;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
    if (advance && res.valid) begin
      kind_r  <= res.kind;
      char_r  <= res.char_code;
      thumb_r <= res.thumb_code;
    end
  end

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.char_timeout         <= CHAR_TIMEOUT_RST;
      cfg_r.thumb_timeout        <= THUMB_TIMEOUT_RST;
      cfg_r.overlap_window       <= OVERLAP_RST;
      cfg_r.dedicated_thumb_keys <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_CHAR_TIMEOUT:  cfg_r.char_timeout         <= cfg_ch.data;
        CFG_THUMB_TIMEOUT: cfg_r.thumb_timeout        <= cfg_ch.data;
        CFG_OVERLAP:       cfg_r.overlap_window       <= cfg_ch.data;
        CFG_DEDICATED:     cfg_r.dedicated_thumb_keys <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: dv/thumb_shift_chord_detector_core_tb.sv
// Self-checking testbench for the thumb-shift chord detector core.
// Depends on tscd_pkg, the three channel interfaces and the core itself.
`timescale 1ns / 1ps

module thumb_shift_chord_detector_core_tb;
  import tscd_pkg::*;

  localparam logic [15:0] SHIFT_CODE = 16'd255;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    KS_IDLE       = 3'd0,
    KS_CHAR       = 3'd1,
    KS_THUMB      = 3'd2,
    KS_CHAR_THUMB = 3'd3,
    KS_THUMB_CHAR = 3'd4
  } kstate_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] key_code;
    logic [31:0] now_ms;
    logic        shift_held;
  } key_ev_t;

  logic clk;
  logic rst_n;

  tscd_in_if  in_ch ();
  tscd_out_if out_ch ();
  tscd_cfg_if cfg_ch ();

  thumb_shift_chord_detector_core #(
    .SHIFT_THUMB_CODE(SHIFT_CODE),
    .TIME_BITS(32)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor copy of the configuration and of the detector state.
  logic [9:0]  char_wait_ms  = CHAR_TIMEOUT_RST;
  logic [9:0]  thumb_wait_ms = THUMB_TIMEOUT_RST;
  logic [9:0]  overlap_ms    = OVERLAP_RST;
  logic        dedicated     = 1'b0;
  kstate_t     kst           = KS_IDLE;
  logic [15:0] held_char     = '0;
  logic [15:0] held_thumb    = '0;
  logic [31:0] char_t0       = '0;
  logic [31:0] thumb_t0      = '0;
  logic [31:0] due_ms        = '0;

  key_ev_t key_event_q[$];
  res_t    stroke_q[$];
  key_ev_t offered;

  int  fail_n = 0;
  int  checked_n = 0;
  int  sent_n = 0;
  int  reg_writes_n = 0;
  int  settings_n = 1;
  int  burst_left = 1;
  int  gap_left = 0;
  int  hold_left = 0;
  int  rx_cycle = 0;
  int  rx_mode = 0;
  int unsigned cycle_n = 0;
  logic dense_send = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  logic [31:0] clock_ms = 32'd0;
  logic [15:0] last_char = 16'h0004;
  logic [15:0] last_thumb = 16'h0F00;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic res_t stroke_of(logic [15:0] ch, logic [15:0] th, logic shift);
    res_t r;
    r = '0;
    if (ch == 16'd0) begin
      if (th != 16'd0) begin
        r.valid = 1'b1;
        r.kind = KIND_THUMB;
        r.thumb_code = th;
      end
    end else begin
      r.valid = 1'b1;
      r.kind = KIND_CHAR;
      r.char_code = ch;
      r.thumb_code = (shift && th == 16'd0) ? SHIFT_CODE : th;
    end
    return r;
  endfunction

  function automatic res_t take_all(logic shift);
    res_t r;
    r = stroke_of(held_char, held_thumb, shift);
    held_char = '0;
    held_thumb = '0;
    return r;
  endfunction

  // The thumb stays pending.
  function automatic res_t take_char(logic shift);
    res_t r;
    r = stroke_of(held_char, 16'd0, shift);
    held_char = '0;
    return r;
  endfunction

  // The character stays pending.
  function automatic res_t take_thumb(logic shift);
    res_t r;
    r = stroke_of(16'd0, held_thumb, shift);
    held_thumb = '0;
    return r;
  endfunction

  function automatic res_t take_long();
    res_t r;
    r = '0;
    if (held_thumb != 16'd0) begin
      r.valid = 1'b1;
      r.kind = KIND_LONG;
      r.thumb_code = held_thumb;
    end
    held_char = '0;
    held_thumb = '0;
    return r;
  endfunction

  function automatic void press_char(logic [15:0] k, logic [31:0] now);
    held_char = k;
    char_t0 = now;
    due_ms = now + {22'd0, char_wait_ms};
  endfunction

  function automatic void press_thumb(logic [15:0] k, logic [31:0] now);
    held_thumb = k;
    thumb_t0 = now;
    due_ms = now + {22'd0, thumb_wait_ms};
  endfunction

  function automatic res_t predict_stroke(key_ev_t e);
    res_t        r;
    logic [31:0] t1;
    logic [31:0] t2;
    logic        sh;
    r = '0;
    sh = e.shift_held;
    if (e.func > EV_TICK) return r;
    // A tick only matters once the deadline has strictly passed.
    if (e.func == EV_TICK) begin
      if (due_ms == 32'd0 || !(e.now_ms > due_ms)) return r;
      due_ms = '0;
    end
    case (kst)
      KS_IDLE: begin
        due_ms = '0;
        char_t0 = '0;
        thumb_t0 = '0;
        held_char = '0;
        held_thumb = '0;
        if (e.func == EV_CHAR) begin
          press_char(e.key_code, e.now_ms);
          kst = KS_CHAR;
        end else if (e.func == EV_THUMB) begin
          press_thumb(e.key_code, e.now_ms);
          kst = KS_THUMB;
        end
      end
      KS_CHAR: begin
        case (e.func)
          EV_INIT: kst = KS_IDLE;
          EV_ALL_OFF, EV_TICK: begin
            r = take_all(sh);
            kst = KS_IDLE;
          end
          EV_CHAR: begin
            r = take_all(sh);
            press_char(e.key_code, e.now_ms);
          end
          EV_THUMB: begin
            press_thumb(e.key_code, e.now_ms);
            kst = KS_CHAR_THUMB;
          end
          EV_RELEASE: begin
            if (e.key_code == held_char) begin
              r = take_all(sh);
              kst = KS_IDLE;
            end
          end
          default: ;
        endcase
      end
      KS_THUMB: begin
        case (e.func)
          EV_INIT: kst = KS_IDLE;
          EV_ALL_OFF: begin
            r = take_all(sh);
            kst = KS_IDLE;
          end
          EV_CHAR: begin
            press_char(e.key_code, e.now_ms);
            kst = KS_THUMB_CHAR;
          end
          EV_THUMB: begin
            r = take_all(sh);
            press_thumb(e.key_code, e.now_ms);
          end
          EV_RELEASE: begin
            if (e.key_code == held_thumb) begin
              r = take_all(sh);
              kst = KS_IDLE;
            end
          end
          EV_TICK: begin
            if (!dedicated) begin
              r = take_long();
              kst = KS_IDLE;
            end
          end
          default: ;
        endcase
      end
      KS_CHAR_THUMB: begin
        t1 = thumb_t0 - char_t0;
        t2 = e.now_ms - thumb_t0;
        case (e.func)
          EV_INIT: kst = KS_IDLE;
          EV_ALL_OFF, EV_TICK: begin
            r = take_all(sh);
            kst = KS_IDLE;
          end
          EV_THUMB: begin
            r = take_all(sh);
            press_thumb(e.key_code, e.now_ms);
            kst = KS_THUMB;
          end
          EV_CHAR: begin
            if (t1 < t2) begin
              r = take_all(sh);
              press_char(e.key_code, e.now_ms);
              kst = KS_CHAR;
            end else begin
              r = take_char(sh);
              press_char(e.key_code, e.now_ms);
              kst = KS_THUMB_CHAR;
            end
          end
          EV_RELEASE: begin
            if (held_char == e.key_code && t2 < {22'd0, overlap_ms} && t1 >= t2) begin
              r = take_char(sh);
              kst = KS_THUMB;
            end else begin
              r = take_all(sh);
              kst = KS_IDLE;
            end
          end
          default: ;
        endcase
      end
      KS_THUMB_CHAR: begin
        t1 = char_t0 - thumb_t0;
        t2 = e.now_ms - char_t0;
        case (e.func)
          EV_INIT: kst = KS_IDLE;
          EV_ALL_OFF, EV_TICK: begin
            r = take_all(sh);
            kst = KS_IDLE;
          end
          EV_CHAR: begin
            r = take_all(sh);
            press_char(e.key_code, e.now_ms);
            kst = KS_CHAR;
          end
          EV_THUMB: begin
            if (t1 < t2) begin
              r = take_all(sh);
              press_thumb(e.key_code, e.now_ms);
              kst = KS_THUMB;
            end else begin
              r = take_thumb(sh);
              press_thumb(e.key_code, e.now_ms);
              kst = KS_CHAR_THUMB;
            end
          end
          EV_RELEASE: begin
            if (held_thumb == e.key_code && t2 < {22'd0, overlap_ms} && t1 >= t2) begin
              r = take_thumb(sh);
              kst = KS_CHAR;
            end else begin
              r = take_all(sh);
              kst = KS_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: kst = KS_IDLE;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Event driver: bursts of transfers separated by random gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : event_driver
    res_t pr;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pr = predict_stroke(offered);
        if (pr.valid) stroke_q.push_back(pr);
        sent_n++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 && !dense_send) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (key_event_q.size() > 0) begin
          offered = key_event_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= offered.func;
          in_ch.key_code <= offered.key_code;
          in_ch.now_ms <= offered.now_ms;
          in_ch.shift_held <= offered.shift_held;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: one of four stall patterns, picked anew at random; one long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stroke_receiver
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (long_hold_req && !long_hold_done) begin
        hold_left = 250;
        long_hold_done = 1'b1;
      end
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stroke monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stroke_monitor
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (stroke_q.size() == 0) begin
        $error("unexpected stroke: kind %0d char_code 0x%04h thumb_code 0x%04h",
               out_ch.kind, out_ch.char_code, out_ch.thumb_code);
        fail_n++;
      end else begin
        want = stroke_q.pop_front();
        checked_n++;
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
          fail_n++;
        end
        if (out_ch.char_code !== want.char_code) begin
          $error("char_code: expected 0x%04h, actual 0x%04h", want.char_code, out_ch.char_code);
          fail_n++;
        end
        if (out_ch.thumb_code !== want.thumb_code) begin
          $error("thumb_code: expected 0x%04h, actual 0x%04h",
                 want.thumb_code, out_ch.thumb_code);
          fail_n++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_ev(logic [2:0] f, logic [15:0] k, logic [31:0] now, logic sh);
    key_ev_t e;
    e.func = f;
    e.key_code = k;
    e.now_ms = now;
    e.shift_held = sh;
    key_event_q.push_back(e);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [9:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reg_writes_n++;
    case (idx)
      CFG_CHAR_TIMEOUT:  char_wait_ms = val;
      CFG_THUMB_TIMEOUT: thumb_wait_ms = val;
      CFG_OVERLAP:       overlap_ms = val;
      CFG_DEDICATED:     dedicated = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [9:0] cto, logic [9:0] tto, logic [9:0] ovl, logic ded);
    write_reg(CFG_CHAR_TIMEOUT, cto);
    write_reg(CFG_THUMB_TIMEOUT, tto);
    write_reg(CFG_OVERLAP, ovl);
    write_reg(CFG_DEDICATED, {9'd0, ded});
    settings_n++;
  endtask

  // Everything sent, every stroke back, then a wait for events that
  // produce nothing but may still sit in the pipeline.
  task automatic wait_idle();
    do @(negedge clk); while (key_event_q.size() != 0 || in_ch.valid || stroke_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Mostly plausible typing: presses, releases of held keys and ticks, with
  // time steps scaled to the current timeouts. A small share is noise.
  task automatic queue_random_events(int n);
    key_ev_t e;
    int      pick;
    int      scale;
    scale = char_wait_ms;
    if (thumb_wait_ms > scale) scale = thumb_wait_ms;
    if (overlap_ms > scale) scale = overlap_ms;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      e.shift_held = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: clock_ms += $urandom_range(0, 1500);
        1: clock_ms += $urandom_range(0, 3);
        default: clock_ms += $urandom_range(0, scale + scale / 2 + 2);
      endcase
      e.now_ms = ($urandom_range(0, 49) == 0) ? $urandom() : clock_ms;
      if (pick < 28) begin
        e.func = EV_CHAR;
        case ($urandom_range(0, 9))
          0: e.key_code = 16'h0000;
          1: e.key_code = 16'hFFFF;
          2: e.key_code = 16'($urandom());
          default: e.key_code = 16'(16'h0004 + $urandom_range(0, 7));
        endcase
        last_char = e.key_code;
      end else if (pick < 50) begin
        e.func = EV_THUMB;
        case ($urandom_range(0, 9))
          0: e.key_code = 16'h0000;
          1: e.key_code = 16'hFFFF;
          2: e.key_code = 16'($urandom());
          default: e.key_code = 16'(16'h0F00 + $urandom_range(0, 3));
        endcase
        last_thumb = e.key_code;
      end else if (pick < 75) begin
        e.func = EV_RELEASE;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: e.key_code = last_char;
          4, 5, 6, 7: e.key_code = last_thumb;
          8: e.key_code = 16'($urandom());
          default: e.key_code = 16'h0000;
        endcase
      end else if (pick < 90) begin
        e.func = EV_TICK;
        e.key_code = 16'($urandom());
      end else if (pick < 94) begin
        e.func = EV_ALL_OFF;
        e.key_code = 16'($urandom());
      end else if (pick < 97) begin
        e.func = EV_INIT;
        e.key_code = 16'($urandom());
      end else begin
        e.func = 3'($urandom_range(6, 7));
        e.key_code = 16'($urandom());
      end
      key_event_q.push_back(e);
    end
  endtask

  initial begin : main_sequence
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = EV_INIT;
    in_ch.key_code = '0;
    in_ch.now_ms = '0;
    in_ch.shift_held = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CHAR_TIMEOUT;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset configuration.
    push_ev(EV_INIT, 16'h0000, 32'd10, 1'b0);
    push_ev(EV_CHAR, 16'h0041, 32'd1000, 1'b0);
    push_ev(EV_TICK, 16'h0000, 32'd1050, 1'b0);     // deadline not yet passed
    push_ev(EV_TICK, 16'h0000, 32'd1101, 1'b1);     // lone character with shift
    push_ev(EV_THUMB, 16'h0F01, 32'd2000, 1'b0);
    push_ev(EV_TICK, 16'h0000, 32'd2101, 1'b0);     // thumb long press
    push_ev(EV_CHAR, 16'h0042, 32'd3000, 1'b0);
    push_ev(EV_THUMB, 16'h0F02, 32'd3010, 1'b0);
    push_ev(EV_RELEASE, 16'h0042, 32'd3020, 1'b0);  // chord split on release
    push_ev(EV_RELEASE, 16'h0F02, 32'd3030, 1'b0);
    push_ev(EV_THUMB, 16'h0F03, 32'd4000, 1'b0);
    push_ev(EV_CHAR, 16'hFFFF, 32'd4005, 1'b1);
    push_ev(EV_THUMB, 16'h0F04, 32'd4100, 1'b0);
    push_ev(EV_ALL_OFF, 16'h0000, 32'd4110, 1'b1);
    push_ev(EV_CHAR, 16'h0000, 32'd5000, 1'b0);     // empty emission
    push_ev(EV_RELEASE, 16'h0000, 32'd5001, 1'b0);
    push_ev(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);   // unknown events are ignored
    push_ev(3'd7, 16'h5A5A, 32'hA5A5_A5A5, 1'b0);
    push_ev(EV_CHAR, 16'h0043, 32'd6000, 1'b0);
    push_ev(EV_RELEASE, 16'h0044, 32'd6010, 1'b0);  // release of a key not pending
    push_ev(EV_ALL_OFF, 16'h0000, 32'd6020, 1'b0);
    push_ev(EV_CHAR, 16'h0045, 32'hFFFF_FF9C, 1'b0); // deadline wraps to zero
    push_ev(EV_TICK, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    push_ev(EV_INIT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Smallest timeouts and window.
    set_regs(10'd1, 10'd1, 10'd1, 1'b0);
    clock_ms = 32'd100000;
    queue_random_events(100);
    wait_idle();

    // Timeouts and window of 1000, long press suppressed.
    set_regs(10'd1000, 10'd1000, 10'd1000, 1'b1);
    queue_random_events(100);
    wait_idle();

    // Random setting, back-to-back events against a long output stall.
    set_regs(10'($urandom_range(1, 1000)), 10'($urandom_range(1, 1000)),
             10'($urandom_range(1, 1000)), 1'($urandom_range(0, 1)));
    dense_send = 1'b1;
    long_hold_req = 1'b1;
    queue_random_events(150);
    wait_idle();
    dense_send = 1'b0;

    // Timestamps run across the 32-bit wrap.
    set_regs(10'd120, 10'd80, 10'd40, 1'b0);
    clock_ms = 32'hFFFF_FC00;
    queue_random_events(150);
    wait_idle();

    set_regs(10'($urandom_range(1, 1000)), 10'($urandom_range(1, 1000)),
             10'($urandom_range(1, 1000)), 1'($urandom_range(0, 1)));
    queue_random_events(150);
    wait_idle();

    $display("Summary: %0d key events sent, %0d strokes checked, %0d register writes",
             sent_n, checked_n, reg_writes_n);
    $display("Summary: %0d register settings, one long output stall, timestamp wrap covered",
             settings_n);
    if (fail_n == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tscd_pkg.sv
rtl/tscd_in_if.sv
rtl/tscd_out_if.sv
rtl/tscd_cfg_if.sv
rtl/tscd_fsm.sv
rtl/thumb_shift_chord_detector_core.sv
dv/thumb_shift_chord_detector_core_tb.sv
